### rtl/core/utf8_slug_filter_core_defines.svh
// Assertion helpers for the slug filter core.
`ifndef UTF8_SLUG_FILTER_CORE_DEFINES_SVH
`define UTF8_SLUG_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define USF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define USF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/usf_pkg.sv
package usf_pkg;

    localparam int CpW = 21;

    localparam logic [CpW-1:0] REPL_CP = 21'h00FFFD;

    localparam logic [6:0] REPL_CHAR_RST = 7'd45;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_REPL_CHAR = 2'd0,
        CFG_MERGE     = 2'd1,
        CFG_GERMAN    = 2'd2,
        CFG_POLISH    = 2'd3
    } t_cfg_idx;

    // what follows the replacement group of one byte
    typedef enum logic [1:0] {
        TAIL_NONE = 2'd0,
        TAIL_END  = 2'd1,
        TAIL_CP   = 2'd2
    } t_tail;

    typedef struct packed {
        logic [6:0] ch;
        logic       valid;
        logic       str_end;
    } t_result;

    typedef struct packed {
        logic       has;
        logic [6:0] ch;
        logic       prev;
    } t_emit;

    function automatic logic [CpW-1:0] map_letter(
        input logic [CpW-1:0] cp,
        input logic           ger,
        input logic           pol
    );
        logic [7:0] a;
        logic       hit_g;
        logic       hit_p;
        a     = 8'd0;
        hit_g = 1'b0;
        hit_p = 1'b0;
        case (cp)
            21'h0000E4: begin a = "a"; hit_g = 1'b1; end
            21'h0000C4: begin a = "A"; hit_g = 1'b1; end
            21'h0000F6: begin a = "o"; hit_g = 1'b1; end
            21'h0000D6: begin a = "O"; hit_g = 1'b1; end
            21'h0000FC: begin a = "u"; hit_g = 1'b1; end
            21'h0000DC: begin a = "U"; hit_g = 1'b1; end
            21'h0000DF: begin a = "s"; hit_g = 1'b1; end
            21'h000105: begin a = "a"; hit_p = 1'b1; end
            21'h000104: begin a = "A"; hit_p = 1'b1; end
            21'h000107: begin a = "c"; hit_p = 1'b1; end
            21'h000106: begin a = "C"; hit_p = 1'b1; end
            21'h000119: begin a = "e"; hit_p = 1'b1; end
            21'h000118: begin a = "E"; hit_p = 1'b1; end
            21'h000142: begin a = "l"; hit_p = 1'b1; end
            21'h000141: begin a = "L"; hit_p = 1'b1; end
            21'h000144: begin a = "n"; hit_p = 1'b1; end
            21'h000143: begin a = "N"; hit_p = 1'b1; end
            21'h0000F3: begin a = "o"; hit_p = 1'b1; end
            21'h0000D3: begin a = "O"; hit_p = 1'b1; end
            21'h00015B: begin a = "s"; hit_p = 1'b1; end
            21'h00015A: begin a = "S"; hit_p = 1'b1; end
            21'h00017C: begin a = "z"; hit_p = 1'b1; end
            21'h00017B: begin a = "Z"; hit_p = 1'b1; end
            21'h00017A: begin a = "z"; hit_p = 1'b1; end
            21'h000179: begin a = "Z"; hit_p = 1'b1; end
            default: ;
        endcase
        if ((hit_g && ger) || (hit_p && pol)) begin
            return {13'd0, a};
        end
        return cp;
    endfunction

    // One decoded nonzero code point: mapped, folded, then passed or replaced.
    function automatic t_emit emit_cp(
        input logic [CpW-1:0] cp_in,
        input logic           prev,
        input logic [6:0]     repl,
        input logic           merge,
        input logic           ger,
        input logic           pol
    );
        logic [CpW-1:0] cp;
        t_emit          e;
        cp = map_letter(cp_in, ger, pol);
        if (cp >= 21'h41 && cp <= 21'h5A) begin
            cp = cp ^ 21'h20;
        end
        if ((cp >= 21'h61 && cp <= 21'h7A) || (cp >= 21'h30 && cp <= 21'h39)
                || cp == {14'd0, repl}) begin
            e.has  = 1'b1;
            e.ch   = cp[6:0];
            e.prev = 1'b0;
        end else begin
            e.has  = !merge || !prev;
            e.ch   = repl;
            e.prev = 1'b1;
        end
        return e;
    endfunction

endpackage

### rtl/core/utf8_slug_filter_core.sv
// UTF-8 to URL-slug filter. Feed one string byte per request on the input
// channel; a zero byte ends the string and yields one string_end request on
// the output. Each input byte is decoded against the pending-sequence state in
// the cycle it is accepted and yields zero to four output requests, which are
// parked in a four-entry result buffer and drained one per cycle unless the
// output stalls; last_of_run marks the final one of each byte. A byte is taken
// every cycle while each byte yields at most one request and the output does
// not stall; one that yields more holds the input off until its last request
// leaves the single-port buffer, one that yields nothing (merged replacement,
// pending continuation, discarded tail) does not. The replacement character,
// run merging and the German/Polish letter maps are set through the write port
// and should be changed only while idle.
module utf8_slug_filter_core
    import usf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [6:0] i_cfg_data,
    // byte input
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    // slug output
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [6:0] o_slug_char,
    output logic       o_char_valid,
    output logic       o_string_end,
    output logic       o_last_of_run
);

    `include "utf8_slug_filter_core_defines.svh"

    // configuration registers
    logic [6:0] r_repl;
    logic       r_merge;
    logic       r_ger;
    logic       r_pol;

    // decoder state
    logic [1:0]     r_exp, n_exp;
    logic [1:0]     r_buf, n_buf;
    logic [CpW-1:0] r_pcp, n_pcp;
    logic           r_prev, n_prev;
    logic           r_discard, n_discard;

    // result buffer: r_left requests remain, starting at r_idx
    t_result    r_res [4];
    t_result    n_list [4];
    logic [2:0] n_cnt;
    logic [1:0] r_idx;
    logic [2:0] r_left;

    logic w_in_acc;
    logic w_out_pop;

    assign o_out_valid = (r_left != 3'd0);
    // a new request may land as the last buffered one leaves
    assign o_in_stall  = (r_left > 3'd1) || (r_left == 3'd1 && i_out_stall);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_pop   = o_out_valid && !i_out_stall;

    assign o_slug_char   = r_res[r_idx].ch;
    assign o_char_valid  = r_res[r_idx].valid;
    assign o_string_end  = r_res[r_idx].str_end;
    assign o_last_of_run = (r_left == 3'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repl  <= REPL_CHAR_RST;
            r_merge <= 1'b1;
            r_ger   <= 1'b1;
            r_pol   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_REPL_CHAR: r_repl  <= i_cfg_data;
                CFG_MERGE:     r_merge <= i_cfg_data[0];
                CFG_GERMAN:    r_ger   <= i_cfg_data[0];
                CFG_POLISH:    r_pol   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Decode one byte: a group of U+FFFD emits (bad continuation and/or stray
    // lead) followed by at most one terminator or code point.
    always_comb begin : p_step
        logic [2:0]     rep_n;
        t_tail          tail;
        logic [CpW-1:0] tail_cp;
        logic [CpW-1:0] pcp_new;
        logic [2:0]     buf_new;
        logic           lead;
        logic           prev;
        logic [2:0]     cnt;
        t_emit          e;

        n_exp     = r_exp;
        n_buf     = r_buf;
        n_pcp     = r_pcp;
        n_discard = r_discard;
        for (int i = 0; i < 4; i++) begin
            n_list[i] = '0;
        end
        rep_n   = 3'd0;
        tail    = TAIL_NONE;
        tail_cp = '0;
        lead    = 1'b0;
        e       = '0;
        pcp_new = {r_pcp[CpW-7:0], i_in_byte[5:0]};
        buf_new = {1'b0, r_buf} + 3'd1;

        if (r_discard) begin
            if (i_in_byte == 8'd0) begin
                n_discard = 1'b0;
            end
        end else if (r_exp != 2'd0) begin
            if (i_in_byte[7:6] == 2'b10) begin
                if (buf_new >= {1'b0, r_exp}) begin
                    n_exp = 2'd0;
                    n_buf = 2'd0;
                    n_pcp = '0;
                    if (pcp_new == '0) begin
                        // overlong zero ends the string early
                        tail      = TAIL_END;
                        n_discard = 1'b1;
                    end else begin
                        tail    = TAIL_CP;
                        tail_cp = pcp_new;
                    end
                end else begin
                    n_pcp = pcp_new;
                    n_buf = buf_new[1:0];
                end
            end else begin
                // one replacement for the lead and one per buffered byte
                rep_n = buf_new;
                n_exp = 2'd0;
                n_buf = 2'd0;
                n_pcp = '0;
                lead  = 1'b1;
            end
        end else begin
            lead = 1'b1;
        end

        if (lead) begin
            if (i_in_byte == 8'd0) begin
                tail = TAIL_END;
            end else if (!i_in_byte[7]) begin
                tail    = TAIL_CP;
                tail_cp = {13'd0, i_in_byte};
            end else if (i_in_byte[7:5] == 3'b110) begin
                n_exp = 2'd1;
                n_buf = 2'd0;
                n_pcp = {16'd0, i_in_byte[4:0]};
            end else if (i_in_byte[7:4] == 4'b1110) begin
                n_exp = 2'd2;
                n_buf = 2'd0;
                n_pcp = {17'd0, i_in_byte[3:0]};
            end else if (i_in_byte[7:3] == 5'b11110) begin
                n_exp = 2'd3;
                n_buf = 2'd0;
                n_pcp = {18'd0, i_in_byte[2:0]};
            end else begin
                rep_n = rep_n + 3'd1;
            end
        end

        prev = r_prev;
        cnt  = 3'd0;
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < rep_n) begin
                e    = emit_cp(REPL_CP, prev, r_repl, r_merge, r_ger, r_pol);
                prev = e.prev;
                if (e.has) begin
                    n_list[cnt[1:0]] = '{ch: e.ch, valid: 1'b1, str_end: 1'b0};
                    cnt = cnt + 3'd1;
                end
            end
        end

        case (tail)
            TAIL_END: begin
                n_list[cnt[1:0]] = '{ch: 7'd0, valid: 1'b0, str_end: 1'b1};
                cnt   = cnt + 3'd1;
                prev  = 1'b0;
                n_exp = 2'd0;
                n_buf = 2'd0;
                n_pcp = '0;
            end
            TAIL_CP: begin
                e    = emit_cp(tail_cp, prev, r_repl, r_merge, r_ger, r_pol);
                prev = e.prev;
                if (e.has) begin
                    n_list[cnt[1:0]] = '{ch: e.ch, valid: 1'b1, str_end: 1'b0};
                    cnt = cnt + 3'd1;
                end
            end
            default: ;
        endcase

        n_prev = prev;
        n_cnt  = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp     <= 2'd0;
            r_buf     <= 2'd0;
            r_pcp     <= '0;
            r_prev    <= 1'b0;
            r_discard <= 1'b0;
            r_idx     <= 2'd0;
            r_left    <= 3'd0;
        end else begin
            if (w_in_acc) begin
                r_exp     <= n_exp;
                r_buf     <= n_buf;
                r_pcp     <= n_pcp;
                r_prev    <= n_prev;
                r_discard <= n_discard;
                r_idx     <= 2'd0;
                r_left    <= n_cnt;
            end else if (w_out_pop) begin
                r_idx  <= r_idx + 2'd1;
                r_left <= r_left - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            for (int i = 0; i < 4; i++) begin
                r_res[i] <= n_list[i];
            end
        end
    end

    `USF_ASSERT_NOW(a_no_overrun, w_in_acc, !o_out_valid || (o_last_of_run && w_out_pop), "overrun")
    `USF_ASSERT_NOW(a_end_shape, o_out_valid && o_string_end, !o_char_valid && ~|o_slug_char, "bad end")
    `USF_ASSERT_NOW(a_discard_idle, r_discard, ~|{r_exp, r_buf}, "pending while discarding")
    `USF_ASSERT_NEXT(a_run_continues, w_out_pop && !o_last_of_run, o_out_valid, "run cut short")

endmodule
